### hdl/vbc_pkg.sv
package vbc_pkg;

   // fixed field widths
   localparam int DIST_W = 11;
   localparam int TIE_W  = 7;
   localparam int CNT_W  = 7;
   localparam int IDX_W  = 6;
   localparam int IN_W   = 10;

   localparam logic [TIE_W-1:0] TIE_MAX = '1;

   // item kinds carried in req_tuser
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // control bits that travel with each seed through the pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

### hdl/vbc_dist_sqrt.sv
module vbc_dist_sqrt #(
   parameter int COORD_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  vbc_pkg::tag_type        in_tag,
   input  logic [COORD_BITS-1:0]   pix_row,
   input  logic [COORD_BITS-1:0]   pix_col,
   input  logic [COORD_BITS-1:0]   seed_row,
   input  logic [COORD_BITS-1:0]   seed_col,
   output vbc_pkg::tag_type        out_tag,
   output logic [COORD_BITS:0]     out_dist
);
   import vbc_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int SW  = 2 * CB + 1;   // squared sum width
   localparam int RW  = CB + 1;       // root width
   localparam int VW  = 2 * RW;       // radicand padded to bit pairs
   localparam int RMW = RW + 3;       // partial remainder width

   // stage 1: absolute differences
   tag_type         t1_ff;
   logic [CB-1:0]   dr_ff, dc_ff;

   always_ff @(posedge clock) begin
      if (reset) t1_ff <= '0;
      else       t1_ff <= in_tag;
      dr_ff <= (pix_row > seed_row) ? pix_row - seed_row : seed_row - pix_row;
      dc_ff <= (pix_col > seed_col) ? pix_col - seed_col : seed_col - pix_col;
   end

   // stage 2: squares
   tag_type           t2_ff;
   logic [2*CB-1:0]   sr_ff, sc_ff;

   always_ff @(posedge clock) begin
      if (reset) t2_ff <= '0;
      else       t2_ff <= t1_ff;
      sr_ff <= dr_ff * dr_ff;
      sc_ff <= dc_ff * dc_ff;
   end

   // stage 3 (root stage 0): exact sum, start of the digit-by-digit root
   tag_type          tag_ff  [0:RW];
   logic [RW-1:0]    root_ff [0:RW];
   logic [RMW-1:0]   rem_ff  [0:RW];
   logic [VW-1:0]    v_ff    [0:RW];
   logic [SW-1:0]    sum_in;

   assign sum_in = SW'(sr_ff) + SW'(sc_ff);

   always_ff @(posedge clock) begin
      if (reset) tag_ff[0] <= '0;
      else       tag_ff[0] <= t2_ff;
      root_ff[0] <= '0;
      rem_ff[0]  <= '0;
      v_ff[0]    <= VW'(sum_in);
   end

   // one root bit per stage, most significant pair first
   for (genvar k = 1; k <= RW; k++) begin : g_root
      logic [RMW-1:0] rem_sh, trial, rem_in;
      logic [RW-1:0]  root_in;

      always_comb begin
         rem_sh = {rem_ff[k-1][RMW-3:0], v_ff[k-1][VW-1 -: 2]};
         trial  = RMW'({root_ff[k-1], 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[k-1][RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[k-1][RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) tag_ff[k] <= '0;
         else       tag_ff[k] <= tag_ff[k-1];
         root_ff[k] <= root_in;
         rem_ff[k]  <= rem_in;
         v_ff[k]    <= v_ff[k-1] << 2;
      end
   end

   assign out_tag  = tag_ff[RW];
   assign out_dist = root_ff[RW];

endmodule

### hdl/voronoi_border_classifier.sv
// Nearest-seed classifier. A load item (tuser 0) writes one seed into the
// table. A query item (tuser 1) walks the first seed_count seeds (at most
// MAX_SEEDS), one seed a cycle through a pipelined distance and square-root
// unit, and returns one item with the floor distance to the nearest seed, the
// number of seeds tied at it and a border flag. From its acceptance to the
// earliest next acceptance a query passes the table read, three arithmetic
// stages, one stage per root bit, minimum tracking and the result hand-off
// (the hand-off alone when seed_count is zero), and waits while the previous
// result stalls on rsp_tready; req_tready is low meanwhile.
// Seeds must be loaded before any query reads them.
module voronoi_border_classifier #(
   parameter int MAX_SEEDS  = 64,
   parameter int COORD_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // seed_index[5:0], row[15:6], col[25:16]
   input  logic                        req_tuser,   // cmd
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,   // nearest_distance[10:0], tie_count[17:11],
                                                    // on_border[18]
   input  logic                        csr_wr_en,
   input  logic [vbc_pkg::CNT_W-1:0]   csr_wr_data  // seed_count
);
   import vbc_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int AW = $clog2(MAX_SEEDS);
   localparam int NW = $clog2(MAX_SEEDS + 1);
   localparam int RW = CB + 1;

   // input fields
   logic [IDX_W-1:0] in_idx;
   logic [CB-1:0]    in_row, in_col;
   logic             req_acc;

   assign in_idx  = req_tdata[IDX_W-1:0];
   assign in_row  = CB'(req_tdata[IDX_W +: IN_W]);
   assign in_col  = CB'(req_tdata[IDX_W+IN_W +: IN_W]);
   assign req_acc = req_tvalid && req_tready;

   // seed count register
   logic [CNT_W-1:0] seed_count_ff;

   always_ff @(posedge clock) begin
      if (reset)          seed_count_ff <= CNT_W'(1);
      else if (csr_wr_en) seed_count_ff <= csr_wr_data;
   end

   logic [NW-1:0] n_sat;
   assign n_sat = (32'(seed_count_ff) > MAX_SEEDS) ? NW'(MAX_SEEDS) : NW'(seed_count_ff);

   // seed table
   logic [2*CB-1:0] seed_mem [MAX_SEEDS];
   logic [2*CB-1:0] rd_data_ff;
   logic [31:0]     ld_idx;

   assign ld_idx = 32'(in_idx);

   // control state
   state_type      state_ff, state_in;
   logic [AW-1:0]  addr_ff;
   logic [NW-1:0]  n_ff;
   logic [CB-1:0]  pix_row_ff, pix_col_ff;
   tag_type        rd_tag_ff, sq_tag;
   logic [RW-1:0]  sq_dist;
   logic           issue, rsp_load, last_issue;

   assign last_issue = (NW'(addr_ff) + NW'(1)) == n_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_acc && req_tuser == CMD_QUERY) begin
               state_in = (n_sat == '0) ? ST_DONE : ST_WALK;
            end
         ST_WALK:
            if (last_issue) state_in = ST_DRAIN;
         ST_DRAIN:
            if (sq_tag.valid && sq_tag.last) state_in = ST_DONE;
         ST_DONE:
            if (!rsp_tvalid || rsp_tready) state_in = ST_IDLE;
         default:
            state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_WALK:  issue      = 1'b1;
         ST_DRAIN: ;
         ST_DONE:  rsp_load   = !rsp_tvalid || rsp_tready;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         addr_ff   <= '0;
         rd_tag_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_tag_ff <= '{valid: issue, last: issue && last_issue};
         if (req_acc) addr_ff <= '0;
         else if (issue) addr_ff <= addr_ff + AW'(1);
      end
   end

   // query latch and table access
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == CMD_QUERY) begin
         pix_row_ff <= in_row;
         pix_col_ff <= in_col;
         n_ff       <= n_sat;
      end
      if (req_acc && req_tuser == CMD_LOAD && ld_idx < MAX_SEEDS) begin
         seed_mem[ld_idx[AW-1:0]] <= {in_col, in_row};
      end
      rd_data_ff <= seed_mem[addr_ff];
   end

   vbc_dist_sqrt #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .pix_row  (pix_row_ff),
      .pix_col  (pix_col_ff),
      .seed_row (rd_data_ff[CB-1:0]),
      .seed_col (rd_data_ff[2*CB-1:CB]),
      .out_tag  (sq_tag),
      .out_dist (sq_dist)
   );

   // minimum and tie tracking
   logic             have_ff;
   logic [RW-1:0]    best_ff;
   logic [TIE_W-1:0] ties_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         best_ff <= '0;
         ties_ff <= '0;
      end else if (req_acc) begin
         have_ff <= 1'b0;
         best_ff <= '0;
         ties_ff <= '0;
      end else if (sq_tag.valid) begin
         if (!have_ff || sq_dist < best_ff) begin
            have_ff <= 1'b1;
            best_ff <= sq_dist;
            ties_ff <= TIE_W'(1);
         end else if (sq_dist == best_ff && ties_ff != TIE_MAX) begin
            ties_ff <= ties_ff + TIE_W'(1);
         end
      end
   end

   // result register
   logic             rsp_valid_ff;
   logic [23:0]      rsp_data_ff;
   logic [DIST_W-1:0] dist_out;

   assign dist_out = DIST_W'(best_ff);

   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (rsp_load)   rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (rsp_load) begin
         rsp_data_ff <= {5'b0, (ties_ff > TIE_W'(1)), ties_ff, dist_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hdl/vbc_checker.sv
module vbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // border flag agrees with the tie count
   a_border: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18] == (rsp_tdata[17:11] > 7'd1)))
      else $error("on_border disagrees with tie_count");

   // no ties means no seeds, hence zero distance
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:11] == 7'd0 |-> rsp_tdata[10:0] == 11'd0)
      else $error("distance without any seed");

   // a stalled result item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed under stall");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind voronoi_border_classifier vbc_checker u_vbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
